// File: sv/dedet_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the dive end detector
// no dependencies; imported by every module of the block
package dedet_pkg;

  localparam int ELAPSED_W = 32;
  localparam int PERIOD_W  = 16;
  localparam int DRY_W     = 8;
  localparam int DEPTH_W   = 16;
  localparam int CFG_DEPTH_W = 15;

  // remainder unit retires two dividend bits per cycle
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = ELAPSED_W / BITS_PER_STEP;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic [DRY_W-1:0] DRY_MAX = '1;

  // input function codes
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // end outcome codes
  localparam logic [2:0] OUTCOME_ONGOING  = 3'd0;
  localparam logic [2:0] OUTCOME_NORMAL   = 3'd1;
  localparam logic [2:0] OUTCOME_LOW_BATT = 3'd2;
  localparam logic [2:0] OUTCOME_USB      = 3'd3;
  localparam logic [2:0] OUTCOME_DISCARD  = 3'd4;

  // register indexes (byte address is 4 * index)
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_VALID_DEPTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SURFACE_DEPTH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DRY_LIM_VALID = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DRY_LIM_UNPRV = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BATT_LOW      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RECORD_PERIOD = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CHECK_PERIOD  = 3'd6;

  // register reset values
  localparam logic [CFG_DEPTH_W-1:0] RST_VALID_DEPTH   = 15'd150;
  localparam logic [CFG_DEPTH_W-1:0] RST_SURFACE_DEPTH = 15'd50;
  localparam logic [DRY_W-1:0]       RST_DRY_LIM_VALID = 8'd10;
  localparam logic [DRY_W-1:0]       RST_DRY_LIM_UNPRV = 8'd60;
  localparam logic [PERIOD_W-1:0]    RST_BATT_LOW      = 16'd3400;
  localparam logic [PERIOD_W-1:0]    RST_RECORD_PERIOD = 16'd1;
  localparam logic [PERIOD_W-1:0]    RST_CHECK_PERIOD  = 16'd60;

  typedef struct packed {
    logic [CFG_DEPTH_W-1:0] valid_depth_cm;
    logic [CFG_DEPTH_W-1:0] surface_depth_cm;
    logic [DRY_W-1:0]       dry_limit_valid;
    logic [DRY_W-1:0]       dry_limit_unproven;
    logic [PERIOD_W-1:0]    battery_low_mv;
    logic [PERIOD_W-1:0]    record_period_s;
    logic [PERIOD_W-1:0]    power_check_period_s;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input transaction fields
    logic start;     // arm a new dive
    logic hold;      // sample on an ended dive, state unchanged
    logic step;      // advance elapsed time, depth check, blink
    logic div;       // one remainder iteration
    logic fin;       // power check, dry count, end decision
    logic out_load;  // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic func;
    logic ended;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_FIN    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

endpackage

// File: sv/dedet_ctrl.sv
`timescale 1ns / 1ps
// sequencing controller for the dive end detector
// depends on dedet_pkg; drives dedet_datapath through cmd_t
module dedet_ctrl import dedet_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.func == FUNC_START) begin
          cmd_o.start = 1'b1;
          state_d     = ST_EMIT;
        end else if (sts_i.ended) begin
          cmd_o.hold = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.step = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/dedet_datapath.sv
`timescale 1ns / 1ps
// dive state registers, iterative remainder unit and result register
// depends on dedet_pkg; commanded by dedet_ctrl
module dedet_datapath import dedet_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic                      func_i,
  input  logic [PERIOD_W-1:0]       initial_elapsed_s_i,
  input  logic                      start_position_ok_i,
  input  logic signed [DEPTH_W-1:0] depth_cm_i,
  input  logic                      water_present_i,
  input  logic [PERIOD_W-1:0]       battery_mv_i,
  input  logic                      usb_present_i,
  output logic [ELAPSED_W-1:0]      record_time_s_o,
  output logic                      dive_valid_o,
  output logic                      dive_ended_o,
  output logic [2:0]                end_outcome_o,
  output logic                      led_level_o
);

  // one restoring step: shift in a bit, subtract the period if it fits
  function automatic logic [PERIOD_W-1:0] rem_step(input logic [PERIOD_W-1:0] rem,
                                                   input logic b,
                                                   input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, p}) begin
      t = t - {1'b0, p};
    end
    return t[PERIOD_W-1:0];
  endfunction

  // captured transaction fields
  logic                      func_q;
  logic [PERIOD_W-1:0]       init_q;
  logic                      spos_q;
  logic signed [DEPTH_W-1:0] depth_q;
  logic                      water_q;
  logic [PERIOD_W-1:0]       batt_q;
  logic                      usb_in_q;

  // dive state
  logic [ELAPSED_W-1:0] elapsed_q;
  logic                 valid_q;
  logic [DRY_W-1:0]     dry_q;
  logic                 ended_q;
  logic                 low_batt_q;
  logic                 usb_q;
  logic                 pos_ok_q;
  logic                 blink_q;
  logic                 led_q;

  // remainder unit
  logic [ELAPSED_W-1:0] div_q;
  logic [PERIOD_W-1:0]  rem_q;
  logic [PERIOD_W-1:0]  period;
  logic [PERIOD_W-1:0]  rem_mid, rem_next;

  logic [ELAPSED_W-1:0] elapsed_sum;
  logic                 deep, shallow, power_hit;
  logic [DRY_W-1:0]     dry_inc, dry_next, limit;
  logic [2:0]           outcome;

  assign sts_o.func  = func_q;
  assign sts_o.ended = ended_q;

  assign period   = (cfg_i.power_check_period_s == '0) ? PERIOD_W'(1)
                                                        : cfg_i.power_check_period_s;
  assign rem_mid  = rem_step(rem_q, div_q[ELAPSED_W-1], period);
  assign rem_next = rem_step(rem_mid, div_q[ELAPSED_W-2], period);

  assign elapsed_sum = elapsed_q + ELAPSED_W'(cfg_i.record_period_s);
  assign deep    = depth_q > $signed({1'b0, cfg_i.valid_depth_cm});
  assign shallow = depth_q < $signed({1'b0, cfg_i.surface_depth_cm});
  assign power_hit = (rem_q == '0);

  assign dry_inc  = (dry_q == DRY_MAX) ? dry_q : dry_q + 1'b1;
  assign dry_next = (shallow && !water_q) ? dry_inc : '0;
  assign limit    = valid_q ? cfg_i.dry_limit_valid : cfg_i.dry_limit_unproven;

  always_comb begin
    if (!ended_q) begin
      outcome = OUTCOME_ONGOING;
    end else if (valid_q && !low_batt_q && !usb_q) begin
      outcome = OUTCOME_NORMAL;
    end else if (valid_q && low_batt_q && pos_ok_q) begin
      outcome = OUTCOME_LOW_BATT;
    end else if (valid_q && usb_q && pos_ok_q) begin
      outcome = OUTCOME_USB;
    end else begin
      outcome = OUTCOME_DISCARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      valid_q    <= 1'b0;
      dry_q      <= '0;
      ended_q    <= 1'b1;
      low_batt_q <= 1'b0;
      usb_q      <= 1'b0;
      pos_ok_q   <= 1'b0;
      blink_q    <= 1'b0;
      func_q     <= FUNC_START;
    end else begin
      if (cmd_i.capture) begin
        func_q <= func_i;
      end
      if (cmd_i.start) begin
        elapsed_q  <= ELAPSED_W'(init_q);
        valid_q    <= 1'b0;
        dry_q      <= '0;
        ended_q    <= 1'b0;
        low_batt_q <= 1'b0;
        usb_q      <= 1'b0;
        pos_ok_q   <= spos_q;
        blink_q    <= 1'b0;
      end
      if (cmd_i.step) begin
        elapsed_q <= elapsed_sum;
        blink_q   <= !blink_q;
        if (!valid_q && deep) begin
          valid_q <= 1'b1;
          dry_q   <= '0;
        end
      end
      if (cmd_i.fin) begin
        dry_q <= dry_next;
        if (power_hit && (batt_q < cfg_i.battery_low_mv)) begin
          low_batt_q <= 1'b1;
          ended_q    <= 1'b1;
        end
        if (power_hit && usb_in_q) begin
          usb_q   <= 1'b1;
          ended_q <= 1'b1;
        end
        if (dry_next >= limit) begin
          ended_q <= 1'b1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      init_q   <= initial_elapsed_s_i;
      spos_q   <= start_position_ok_i;
      depth_q  <= depth_cm_i;
      water_q  <= water_present_i;
      batt_q   <= battery_mv_i;
      usb_in_q <= usb_present_i;
    end
    if (cmd_i.start) begin
      led_q <= 1'b0;
    end
    if (cmd_i.hold || cmd_i.step) begin
      led_q <= blink_q;
    end
    if (cmd_i.step) begin
      div_q <= elapsed_sum;
      rem_q <= '0;
    end
    if (cmd_i.div) begin
      div_q <= {div_q[ELAPSED_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
      rem_q <= rem_next;
    end
    if (cmd_i.out_load) begin
      record_time_s_o <= elapsed_q;
      dive_valid_o    <= valid_q;
      dive_ended_o    <= ended_q;
      end_outcome_o   <= outcome;
      led_level_o     <= led_q;
    end
  end

endmodule

// File: sv/dive_end_detector_core.sv
`timescale 1ns / 1ps
// top level of the dive end detector: register file, controller, datapath
// depends on dedet_pkg, dedet_ctrl and dedet_datapath
//
// usage:
//  - input channel (in_valid_i / in_ready_o) takes one transaction per start
//    or sample; func_i low arms a new dive, func_i high is one sample
//  - output channel (out_valid_o / out_ready_i) gives exactly one result
//    transaction per input transaction, in order
//  - a start or a sample on an ended dive goes from acceptance through decode
//    to the result register; a live sample also runs the remainder unit, which
//    reduces elapsed time modulo the check period at two bits per cycle
//    (16 iterations), then the end decision; one item is in work at a time
//  - the result sits in an output register, so the next transaction is taken
//    while an earlier result still waits; a stalled receiver holds the block
//    only once the next result is ready to leave
//  - after reset the dive is ended with no valid flag, so samples report
//    discard until a start arrives; registers return to their defaults
//  - registers are written over the apb port at byte address 4 * index; the user is
//    bound to write them only while no transaction is in work; the block has no guard for it
module dive_end_detector_core import dedet_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // apb register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [PERIOD_W-1:0]       initial_elapsed_s_i,
  input  logic                      start_position_ok_i,
  input  logic signed [DEPTH_W-1:0] depth_cm_i,
  input  logic                      water_present_i,
  input  logic [PERIOD_W-1:0]       battery_mv_i,
  input  logic                      usb_present_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ELAPSED_W-1:0]      record_time_s_o,
  output logic                      dive_valid_o,
  output logic                      dive_ended_o,
  output logic [2:0]                end_outcome_o,
  output logic                      led_level_o
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // register file, zero wait state
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valid_depth_cm       <= RST_VALID_DEPTH;
      cfg_q.surface_depth_cm     <= RST_SURFACE_DEPTH;
      cfg_q.dry_limit_valid      <= RST_DRY_LIM_VALID;
      cfg_q.dry_limit_unproven   <= RST_DRY_LIM_UNPRV;
      cfg_q.battery_low_mv       <= RST_BATT_LOW;
      cfg_q.record_period_s      <= RST_RECORD_PERIOD;
      cfg_q.power_check_period_s <= RST_CHECK_PERIOD;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_VALID_DEPTH:   cfg_q.valid_depth_cm       <= pwdata[CFG_DEPTH_W-1:0];
        REG_SURFACE_DEPTH: cfg_q.surface_depth_cm     <= pwdata[CFG_DEPTH_W-1:0];
        REG_DRY_LIM_VALID: cfg_q.dry_limit_valid      <= pwdata[DRY_W-1:0];
        REG_DRY_LIM_UNPRV: cfg_q.dry_limit_unproven   <= pwdata[DRY_W-1:0];
        REG_BATT_LOW:      cfg_q.battery_low_mv       <= pwdata[PERIOD_W-1:0];
        REG_RECORD_PERIOD: cfg_q.record_period_s      <= pwdata[PERIOD_W-1:0];
        REG_CHECK_PERIOD:  cfg_q.power_check_period_s <= pwdata[PERIOD_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read mux, zero-extended
  always_comb begin
    case (reg_idx)
      REG_VALID_DEPTH:   prdata = 32'(cfg_q.valid_depth_cm);
      REG_SURFACE_DEPTH: prdata = 32'(cfg_q.surface_depth_cm);
      REG_DRY_LIM_VALID: prdata = 32'(cfg_q.dry_limit_valid);
      REG_DRY_LIM_UNPRV: prdata = 32'(cfg_q.dry_limit_unproven);
      REG_BATT_LOW:      prdata = 32'(cfg_q.battery_low_mv);
      REG_RECORD_PERIOD: prdata = 32'(cfg_q.record_period_s);
      REG_CHECK_PERIOD:  prdata = 32'(cfg_q.power_check_period_s);
      default:           prdata = '0;
    endcase
  end

  assign in_ready_o = in_ready;

  // sequencer: decode, remainder iterations, end decision, result hand-off
  dedet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // dive state, remainder unit and result register
  dedet_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .func_i              (func_i),
    .initial_elapsed_s_i (initial_elapsed_s_i),
    .start_position_ok_i (start_position_ok_i),
    .depth_cm_i          (depth_cm_i),
    .water_present_i     (water_present_i),
    .battery_mv_i        (battery_mv_i),
    .usb_present_i       (usb_present_i),
    .record_time_s_o     (record_time_s_o),
    .dive_valid_o        (dive_valid_o),
    .dive_ended_o        (dive_ended_o),
    .end_outcome_o       (end_outcome_o),
    .led_level_o         (led_level_o)
  );

endmodule
